// ----- sv/gmcp_pkg.sv -----
// Package: types, constants and helpers for the grid min-cost path block.
`default_nettype none
package gmcp_pkg;
    localparam int ROWS_DEF = 32;
    localparam int COLS_DEF = 64;
    localparam int RW = 5;
    localparam int CW = 6;
    localparam int COST_W = 7;
    localparam int DIR_W = 2;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_RUN   = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;  // unused code, ignored

    localparam logic [DIR_W-1:0] DIR_DOWN = 2'd0;
    localparam logic [DIR_W-1:0] DIR_LEFT = 2'd1;
    localparam logic [DIR_W-1:0] DIR_UP   = 2'd2;

    typedef struct packed {
        logic [1:0]    action;
        logic [RW-1:0] cell_row;
        logic [CW-1:0] cell_col;
        logic          cell_bit;
        logic [RW-1:0] start_row;
        logic [CW-1:0] start_col;
        logic [RW-1:0] stop_row;
        logic [CW-1:0] stop_col;
    } in_word_t;

    typedef struct packed {
        logic [RW-1:0]     path_row;
        logic [CW-1:0]     path_col;
        logic [COST_W-1:0] acc_cost;
        logic              on_peak;
        logic              invalid;
        logic              last;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHECK, ST_WR, ST_INIT, ST_FILL, ST_TRACE_RD, ST_TRACE_WT, ST_TRACE,
        ST_EMIT_RD, ST_EMIT_WT, ST_EMIT, ST_REJECT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch input word
        logic do_write;  // cell write / clear
        logic init;      // seed start cell, set col/row counters
        logic fill_step; // one sweep step: a cell, or a column advance
        logic tr_init;
        logic tr_rd;     // back-dir read state (not used by the datapath)
        logic tr_step;   // record path row, step
        logic em_init;
        logic em_rd;     // emit read state (not used by the datapath)
        logic em_load;   // load output register
        logic g_emit;    // grid read at the emit column
        logic rej_load;
        logic out_take;  // output word accepted
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_write;
        logic is_clear;
        logic is_run;
        logic bad;
        logic fill_done;
        logic tr_done;
        logic em_done;
    } status_t;
endpackage
`default_nettype wire

// ----- sv/grid_min_cost_path_dp.sv -----
// Top level of the grid min-cost path block.
// A cell write passes CHECK and WR, a clear passes CHECK only, before in_ready returns.
// A run: accept, check, seed the start cell, sweep the columns from start to stop,
// trace back per column, then emit a word per column while out_ready holds.
// The block takes one item at a time; in_ready is high only while idle.
// Reset (rst_n, async low): grid reads all ones, controller idle, no output.
`default_nettype none
module grid_min_cost_path_dp #(
    parameter int ROWS = gmcp_pkg::ROWS_DEF,
    parameter int COLS = gmcp_pkg::COLS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire gmcp_pkg::in_word_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output gmcp_pkg::out_word_t      out_data
);
    import gmcp_pkg::*;
    cmd_t    cmd;
    status_t sts;

    // sequencer
    gmcp_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd));

    // grid, sweep, trace-back and output register
    gmcp_datapath #(.ROWS(ROWS), .COLS(COLS)) u_dp (
        .clk(clk), .rst_n(rst_n), .in_word(in_data), .cmd(cmd), .sts(sts),
        .out_word(out_data));
endmodule
`default_nettype wire

// ----- sv/gmcp_ram.sv -----
// Generic single-port-write, single-read RAM with registered read.
`default_nettype none
module gmcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- sv/gmcp_ctrl.sv -----
// Controller state machine for the grid min-cost path block.
`default_nettype none
module gmcp_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire gmcp_pkg::status_t sts,
    output gmcp_pkg::cmd_t         cmd
);
    import gmcp_pkg::*;
    state_t state_reg, state_next;
    logic   ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;
    assign in_ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg;
        cmd        = '0;
        cmd.out_take = ov_reg && out_ready;
        if (cmd.out_take)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.is_clear)
                begin
                    cmd.do_write = 1'b1;
                    state_next   = ST_IDLE;
                end
                else if (sts.is_write)
                begin
                    state_next = ST_WR;
                end
                else if (!sts.is_run)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.bad)
                begin
                    state_next = ST_REJECT;
                end
                else
                begin
                    state_next = ST_INIT;
                end
            end
            ST_WR:
            begin
                cmd.do_write = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = ST_FILL;
            end
            ST_FILL:
            begin
                if (sts.fill_done)
                begin
                    cmd.tr_init = 1'b1;
                    state_next  = ST_TRACE_RD;
                end
                else
                begin
                    cmd.fill_step = 1'b1;
                end
            end
            ST_TRACE_RD:
            begin
                cmd.tr_rd  = 1'b1;
                state_next = ST_TRACE_WT;
            end
            ST_TRACE_WT: state_next = ST_TRACE;
            ST_TRACE:
            begin
                cmd.tr_step = 1'b1;
                if (sts.tr_done)
                begin
                    cmd.em_init = 1'b1;
                    state_next  = ST_EMIT_RD;
                end
                else
                begin
                    state_next = ST_TRACE_RD;
                end
            end
            ST_EMIT_RD:
            begin
                cmd.g_emit = 1'b1;
                if (!ov_next)
                begin
                    cmd.em_rd  = 1'b1;
                    state_next = ST_EMIT_WT;
                end
            end
            ST_EMIT_WT:
            begin
                cmd.g_emit = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.g_emit  = 1'b1;
                cmd.em_load = 1'b1;
                ov_next     = 1'b1;
                state_next  = sts.em_done ? ST_IDLE : ST_EMIT_RD;
            end
            ST_REJECT:
            begin
                if (!ov_next)
                begin
                    cmd.rej_load = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ----- sv/gmcp_datapath.sv -----
// Datapath: cell grid, cost and direction memories, sweep, trace and emit.
`default_nettype none
module gmcp_datapath #(
    parameter int ROWS = gmcp_pkg::ROWS_DEF,
    parameter int COLS = gmcp_pkg::COLS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire gmcp_pkg::in_word_t in_word,
    input  wire gmcp_pkg::cmd_t     cmd,
    output gmcp_pkg::status_t       sts,
    output gmcp_pkg::out_word_t     out_word
);
    import gmcp_pkg::*;
    localparam int RI = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CI = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int AW = RI + CI;
    localparam int DEPTH = 1 << AW;

    in_word_t w_reg;

    // sweep state
    logic [CI-1:0] col_reg;
    logic [RI:0]   row_reg;
    logic [RI-1:0] sr_reg, er_reg;
    logic [CI-1:0] sc_reg, ec_reg;
    // previous-column costs held in a row of registers (with cone flags)
    logic [COST_W-1:0] prev_cost [ROWS];
    logic [ROWS-1:0]   prev_in;
    logic [COST_W-1:0] cur_cost  [ROWS];
    logic [ROWS-1:0]   cur_in;
    logic [RI-1:0]     tr_row_reg;
    logic [CI-1:0]     tr_col_reg;
    logic [CI-1:0]     em_k_reg;
    logic [CI-1:0]     em_col;
    out_word_t         ow_reg;

    // grid: one row mask per column; a column not written since clear reads all ones
    logic [COLS-1:0]   gvalid_reg;
    logic              gv_q_reg;
    logic              g_we;
    logic [CI-1:0]     g_waddr, g_raddr;
    logic [ROWS-1:0]   g_wdata, g_rdata, gcol;
    logic [RI-1:0]     path_rdata;

    // memory ports
    logic              cost_we, dir_we;
    logic [AW-1:0]     cost_waddr, cost_raddr, dir_raddr;
    logic [COST_W-1:0] cost_wdata, cost_rdata;
    logic [DIR_W-1:0]  dir_wdata, dir_rdata;

    gmcp_ram #(.WIDTH(COST_W), .DEPTH(DEPTH)) u_cost (
        .clk(clk), .we(cost_we), .waddr(cost_waddr), .wdata(cost_wdata),
        .raddr(cost_raddr), .rdata(cost_rdata));
    gmcp_ram #(.WIDTH(DIR_W), .DEPTH(DEPTH)) u_dir (
        .clk(clk), .we(dir_we), .waddr(cost_waddr), .wdata(dir_wdata),
        .raddr(dir_raddr), .rdata(dir_rdata));
    gmcp_ram #(.WIDTH(ROWS), .DEPTH(COLS)) u_grid (
        .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
        .raddr(g_raddr), .rdata(g_rdata));
    // path row per column, written by the trace, read back by the emit
    gmcp_ram #(.WIDTH(RI), .DEPTH(COLS)) u_path (
        .clk(clk), .we(cmd.tr_step), .waddr(tr_col_reg), .wdata(tr_row_reg),
        .raddr(em_col), .rdata(path_rdata));

    assign gcol   = gv_q_reg ? g_rdata : '1;
    assign em_col = CI'(sc_reg + em_k_reg);

    // validity checks
    logic [RW:0] dr;
    logic [CW:0] dc;
    always_comb
    begin
        dr = (w_reg.stop_row >= w_reg.start_row)
           ? {1'b0, w_reg.stop_row - w_reg.start_row}
           : {1'b0, w_reg.start_row - w_reg.stop_row};
        dc = {1'b0, w_reg.stop_col} - {1'b0, w_reg.start_col};
        sts.is_write = (w_reg.action == ACT_WRITE);
        sts.is_clear = (w_reg.action == ACT_CLEAR);
        sts.is_run   = (w_reg.action == ACT_RUN);
        sts.bad = (32'(w_reg.start_row) >= ROWS) || (32'(w_reg.stop_row) >= ROWS)
               || (32'(w_reg.start_col) >= COLS) || (32'(w_reg.stop_col) >= COLS)
               || (w_reg.stop_col < w_reg.start_col) || ({1'b0, dr} > {1'b0, dc});
        sts.fill_done = (col_reg == ec_reg) && (row_reg == 0);
        sts.tr_done   = (tr_col_reg == sc_reg);
        sts.em_done   = (em_col == ec_reg);
    end

    // grid access: read-modify-write for a cell, column reads for sweep and emit
    always_comb
    begin
        g_waddr = w_reg.cell_col[CI-1:0];
        g_wdata = gcol;
        g_wdata[w_reg.cell_row[RI-1:0]] = w_reg.cell_bit;
        g_we    = cmd.do_write && sts.is_write
               && (32'(w_reg.cell_row) < ROWS) && (32'(w_reg.cell_col) < COLS);
        if (cmd.fill_step && row_reg == 0)
        begin
            g_raddr = col_reg + 1'b1;  // next column ready when its rows start
        end
        else if (cmd.fill_step)
        begin
            g_raddr = col_reg;
        end
        else if (cmd.g_emit)
        begin
            g_raddr = em_col;
        end
        else if (sts.is_write)
        begin
            g_raddr = w_reg.cell_col[CI-1:0];
        end
        else
        begin
            g_raddr = w_reg.start_col[CI-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gvalid_reg <= '0;
            gv_q_reg   <= 1'b0;
        end
        else
        begin
            gv_q_reg <= gvalid_reg[g_raddr];
            if (cmd.do_write && sts.is_clear)
            begin
                gvalid_reg <= '0;
            end
            else if (g_we)
            begin
                gvalid_reg[g_waddr] <= 1'b1;
            end
        end
    end

    // one cell of the sweep: row_reg counts ROWS..1 as the row index +1
    logic [RI-1:0]     rr;
    logic              c_in, h_dn, h_up;
    logic [COST_W-1:0] best;
    logic [DIR_W-1:0]  bdir;
    logic [CI:0]       cdist;
    logic [COST_W:0]   sum;
    always_comb
    begin
        rr    = RI'(row_reg - 1'b1);
        cdist = {1'b0, col_reg - sc_reg};
        c_in  = 32'((({1'b0, rr} >= {1'b0, sr_reg}) ? ({1'b0, rr} - {1'b0, sr_reg})
                : ({1'b0, sr_reg} - {1'b0, rr}))) <= 32'(cdist);
        h_dn  = (rr != 0) && prev_in[(rr == 0) ? rr : rr - 1'b1];
        h_up  = (32'(rr) + 1 < ROWS) && prev_in[(32'(rr) + 1 < ROWS) ? rr + 1'b1 : rr];
        best  = '1;
        bdir  = DIR_LEFT;
        if (h_dn)
        begin
            best = prev_cost[rr - 1'b1];
            bdir = DIR_DOWN;
        end
        if (prev_in[rr] && (!h_dn || prev_cost[rr] < best))
        begin
            best = prev_cost[rr];
            bdir = DIR_LEFT;
        end
        if (h_up && prev_cost[rr + 1'b1] < best)
        begin
            best = prev_cost[rr + 1'b1];
            bdir = DIR_UP;
        end
        sum = {1'b0, best} + (COST_W+1)'(gcol[rr]);
        if (sum[COST_W])
        begin
            sum = '1;
        end
    end

    // memory control
    always_comb
    begin
        cost_we    = 1'b0;
        dir_we     = 1'b0;
        cost_waddr = {rr, col_reg};
        cost_wdata = sum[COST_W-1:0];
        dir_wdata  = bdir;
        if (cmd.init)
        begin
            cost_we    = 1'b1;
            dir_we     = 1'b1;
            cost_waddr = {w_reg.start_row[RI-1:0], w_reg.start_col[CI-1:0]};
            cost_wdata = COST_W'(gcol[w_reg.start_row[RI-1:0]]);
            dir_wdata  = DIR_LEFT;
        end
        else if (cmd.fill_step && row_reg != 0 && c_in)
        begin
            cost_we = 1'b1;
            dir_we  = 1'b1;
        end
        dir_raddr  = {tr_row_reg, tr_col_reg};
        cost_raddr = {path_rdata, em_col};
    end

    logic [RI:0] nr;
    always_comb
    begin
        nr = {1'b0, tr_row_reg} + (RI+1)'(dir_rdata) - 1'b1;
        if ({1'b0, tr_row_reg} + (RI+1)'(dir_rdata) == 0)
        begin
            nr = '0;
        end
        else if (32'(nr) >= ROWS)
        begin
            nr = (RI+1)'(ROWS - 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            w_reg <= in_word;
        end
        if (cmd.init)
        begin
            sr_reg  <= w_reg.start_row[RI-1:0];
            sc_reg  <= w_reg.start_col[CI-1:0];
            er_reg  <= w_reg.stop_row[RI-1:0];
            ec_reg  <= w_reg.stop_col[CI-1:0];
            col_reg <= w_reg.start_col[CI-1:0];
            row_reg <= '0;
            for (int r = 0; r < ROWS; r++)
            begin
                prev_in[r] <= (r == 32'(w_reg.start_row));
                prev_cost[r] <= COST_W'(gcol[r]);
                cur_in[r] <= 1'b0;
            end
        end
        else if (cmd.fill_step)
        begin
            if (row_reg == 0)
            begin
                col_reg <= col_reg + 1'b1;
                row_reg <= (RI+1)'(ROWS);
            end
            else
            begin
                cur_cost[rr] <= sum[COST_W-1:0];
                cur_in[rr]   <= c_in;
                if (row_reg == 1)
                begin
                    // column complete: cur becomes prev, row 0 straight from this cell
                    for (int r = 1; r < ROWS; r++)
                    begin
                        prev_cost[r] <= cur_cost[r];
                        prev_in[r]   <= cur_in[r];
                    end
                    prev_cost[0] <= sum[COST_W-1:0];
                    prev_in[0]   <= c_in;
                end
                row_reg <= row_reg - 1'b1;
            end
        end
        if (cmd.tr_init)
        begin
            tr_row_reg <= er_reg;
            tr_col_reg <= ec_reg;
        end
        if (cmd.tr_step)
        begin
            tr_row_reg <= nr[RI-1:0];
            tr_col_reg <= tr_col_reg - 1'b1;
        end
        if (cmd.em_init)
        begin
            em_k_reg <= '0;
        end
        if (cmd.em_load)
        begin
            ow_reg.path_row <= RW'(path_rdata);
            ow_reg.path_col <= CW'(em_col);
            ow_reg.acc_cost <= cost_rdata;
            ow_reg.on_peak  <= ~gcol[path_rdata];
            ow_reg.invalid  <= 1'b0;
            ow_reg.last     <= sts.em_done;
            em_k_reg        <= em_k_reg + 1'b1;
        end
        if (cmd.rej_load)
        begin
            ow_reg <= '0;
            ow_reg.invalid <= 1'b1;
            ow_reg.last    <= 1'b1;
        end
    end

    assign out_word = ow_reg;
endmodule
`default_nettype wire
